// ===== rtl/gre_enc_pkg.sv =====
// Shared types and constants for the GRE over IPv4 encapsulator.
package gre_enc_pkg;

    localparam int HDR_BYTES         = 34;
    localparam int OUT_HDR_BYTES     = 58;
    localparam int ETH_HDR           = 14;
    localparam int GRE_EXTRA         = 24;
    localparam int DEFAULT_MAX_FRAME = 1514;
    localparam int HDR_CNT_W         = $clog2(HDR_BYTES);
    localparam int EMIT_CNT_W        = $clog2(OUT_HDR_BYTES + 1);
    localparam int CSUM_W            = 20;
    localparam int CFG_ADDR_W        = 2;
    localparam int CFG_DATA_W        = 48;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] GRE_FLAGS  = 16'h0000;
    localparam logic [7:0]  VER_IHL    = 8'h45;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [7:0]  PROTO_GRE  = 8'd47;

    localparam logic [CFG_ADDR_W-1:0] CFG_NEXT_HOP_MAC  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_EGRESS_MAC    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TUNNEL_SRC_IP = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_TUNNEL_DST_IP = 2'd3;

    typedef struct packed {
        logic [47:0] next_hop_mac;
        logic [47:0] egress_mac;
        logic [31:0] tunnel_src_ip;
        logic [31:0] tunnel_dst_ip;
    } cfg_t;

    typedef logic [OUT_HDR_BYTES-1:0][7:0] frame_t;

    typedef struct packed {
        logic   load;
        logic   last;
        frame_t frame;
    } hdr_load_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } pass_t;

    typedef struct packed {
        logic busy;
        logic slot_free;
    } emit_status_t;

endpackage

// ===== rtl/gre_enc_if.sv =====
// Input and output item channels of the GRE encapsulator.
interface gre_enc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;
    logic       on_receive;

    modport source (output valid, output in_byte, output in_last, output on_receive,
                    input ready);
    modport sink (input valid, input in_byte, input in_last, input on_receive,
                  output ready);
endinterface

interface gre_enc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== rtl/gre_ipv4_encapsulator_core.sv =====
// Top level of the GRE over IPv4 encapsulator: configuration registers and wiring.
// A passed byte enters the output register when accepted; a tunneled frame's header is
// loaded into the burst buffer with the 34th input byte, then shifted to the output
// register. Throughput: 1 byte per cycle while the output is not stalled; the 58-byte
// header burst added per tunneled frame holds off input (longer under output stalls).
// Reset: rst_n clears frame state, burst count, output valid and the
// configuration registers; no clearing pass.
module gre_ipv4_encapsulator_core #(
    parameter int MAX_FRAME = gre_enc_pkg::DEFAULT_MAX_FRAME
) (
    input  logic                               clk,
    input  logic                               rst_n,
    gre_enc_in_if.sink                         ingress,
    gre_enc_out_if.source                      egress,
    input  logic                               cfg_we,
    input  logic [gre_enc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [gre_enc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    gre_enc_pkg::cfg_t         cfg_reg;
    gre_enc_pkg::emit_status_t status;
    gre_enc_pkg::pass_t        pass;
    gre_enc_pkg::hdr_load_t    hdr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                gre_enc_pkg::CFG_NEXT_HOP_MAC:  cfg_reg.next_hop_mac  <= cfg_wdata;
                gre_enc_pkg::CFG_EGRESS_MAC:    cfg_reg.egress_mac    <= cfg_wdata;
                gre_enc_pkg::CFG_TUNNEL_SRC_IP: cfg_reg.tunnel_src_ip <= cfg_wdata[31:0];
                gre_enc_pkg::CFG_TUNNEL_DST_IP: cfg_reg.tunnel_dst_ip <= cfg_wdata[31:0];
                default:                        cfg_reg <= cfg_reg;
            endcase
        end
    end

    gre_enc_parse #(
        .MAX_FRAME (MAX_FRAME)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (ingress.valid),
        .in_byte    (ingress.in_byte),
        .in_last    (ingress.in_last),
        .on_receive (ingress.on_receive),
        .status     (status),
        .in_ready   (ingress.ready),
        .pass       (pass),
        .hdr        (hdr)
    );

    gre_enc_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .hdr       (hdr),
        .pass      (pass),
        .out_ready (egress.ready),
        .status    (status),
        .out_valid (egress.valid),
        .out_byte  (egress.out_byte),
        .out_last  (egress.out_last)
    );

endmodule

// ===== rtl/gre_enc_parse.sv =====
// Header capture, checksum pipeline, tunnel decision and outer header assembly.
module gre_enc_parse #(
    parameter int MAX_FRAME = gre_enc_pkg::DEFAULT_MAX_FRAME
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  gre_enc_pkg::cfg_t        cfg,
    input  logic                     in_valid,
    input  logic [7:0]               in_byte,
    input  logic                     in_last,
    input  logic                     on_receive,
    input  gre_enc_pkg::emit_status_t status,
    output logic                     in_ready,
    output gre_enc_pkg::pass_t       pass,
    output gre_enc_pkg::hdr_load_t   hdr
);

    localparam int LEN_LIMIT = MAX_FRAME - gre_enc_pkg::GRE_EXTRA - gre_enc_pkg::ETH_HDR;
    localparam int CW        = gre_enc_pkg::CSUM_W;
    localparam int HW        = gre_enc_pkg::HDR_CNT_W;

    typedef enum logic [1:0] {
        COLLECT,
        PASS,
        DROP
    } mode_t;

    mode_t                                    mode_reg, mode_next;
    logic [HW-1:0]                            cnt_reg, cnt_next;
    logic [gre_enc_pkg::HDR_BYTES-2:0][7:0]   hs_reg;
    logic [CW-1:0]                            acc_reg, acc_next;
    logic [CW-1:0]                            cfg_sum_reg;
    logic [CW-1:0]                            sum_reg;
    logic [16:0]                              fold_reg;
    logic [15:0]                              cs_reg;
    logic [CW-1:0]                            contrib;
    logic                                     accept;
    logic                                     decide;
    logic                                     qualify;
    logic [15:0]                              ip_len;
    logic [15:0]                              out_len;
    logic [15:0]                              etype;
    logic [7:0]                               proto;
    gre_enc_pkg::frame_t                      frame;

    assign in_ready = !status.busy && (mode_reg != PASS || status.slot_free);
    assign accept   = in_valid && in_ready;
    assign decide   = accept && mode_reg == COLLECT
                      && cnt_reg == HW'(gre_enc_pkg::HDR_BYTES - 1);

    assign ip_len  = {hs_reg[16], hs_reg[17]};
    assign etype   = {hs_reg[12], hs_reg[13]};
    assign proto   = hs_reg[23];
    assign out_len = ip_len + 16'(gre_enc_pkg::GRE_EXTRA);
    assign qualify = on_receive && etype == gre_enc_pkg::ETYPE_IPV4
                     && (proto == gre_enc_pkg::PROTO_TCP || proto == gre_enc_pkg::PROTO_UDP)
                     && {1'b0, ip_len} <= 17'(LEN_LIMIT);

    always_comb
    begin
        case (cnt_reg) inside
            HW'(15), HW'(17), HW'(19), HW'(21): contrib = CW'(in_byte);
            HW'(16), HW'(18), HW'(20), HW'(22): contrib = CW'({in_byte, 8'h00});
            default:                            contrib = '0;
        endcase
        acc_next = (cnt_reg == '0 ? '0 : acc_reg) + contrib;
    end

    always_comb
    begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        if (accept)
        begin
            unique case (mode_reg)
                COLLECT:
                begin
                    if (decide)
                    begin
                        cnt_next  = '0;
                        mode_next = in_last ? COLLECT : (qualify ? PASS : DROP);
                    end
                    else
                    begin
                        cnt_next = in_last ? '0 : cnt_reg + 1'b1;
                    end
                end
                PASS, DROP:
                begin
                    if (in_last)
                    begin
                        mode_next = COLLECT;
                        cnt_next  = '0;
                    end
                end
                default:
                begin
                    mode_next = COLLECT;
                    cnt_next  = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            frame[i]     = cfg.next_hop_mac[47 - 8 * i -: 8];
            frame[6 + i] = cfg.egress_mac[47 - 8 * i -: 8];
        end
        frame[12] = hs_reg[12];
        frame[13] = hs_reg[13];
        frame[14] = gre_enc_pkg::VER_IHL;
        frame[15] = hs_reg[15];
        frame[16] = out_len[15:8];
        frame[17] = out_len[7:0];
        for (int i = 18; i < 23; i++)
        begin
            frame[i] = hs_reg[i];
        end
        frame[23] = gre_enc_pkg::PROTO_GRE;
        frame[24] = cs_reg[15:8];
        frame[25] = cs_reg[7:0];
        for (int i = 0; i < 4; i++)
        begin
            frame[26 + i] = cfg.tunnel_src_ip[31 - 8 * i -: 8];
            frame[30 + i] = cfg.tunnel_dst_ip[31 - 8 * i -: 8];
        end
        frame[34] = gre_enc_pkg::GRE_FLAGS[15:8];
        frame[35] = gre_enc_pkg::GRE_FLAGS[7:0];
        frame[36] = gre_enc_pkg::ETYPE_IPV4[15:8];
        frame[37] = gre_enc_pkg::ETYPE_IPV4[7:0];
        for (int i = 0; i < 19; i++)
        begin
            frame[38 + i] = hs_reg[14 + i];
        end
        frame[57] = in_byte;
    end

    assign hdr.load   = decide && qualify;
    assign hdr.last   = in_last;
    assign hdr.frame  = frame;
    assign pass.valid = accept && mode_reg == PASS;
    assign pass.data  = in_byte;
    assign pass.last  = in_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= COLLECT;
            cnt_reg  <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            if (accept && mode_reg == COLLECT)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && mode_reg == COLLECT)
        begin
            hs_reg <= {in_byte, hs_reg[gre_enc_pkg::HDR_BYTES-2:1]};
        end
        cfg_sum_reg <= CW'({gre_enc_pkg::VER_IHL, 8'h00})
                       + CW'(gre_enc_pkg::GRE_EXTRA)
                       + CW'(gre_enc_pkg::PROTO_GRE)
                       + CW'(cfg.tunnel_src_ip[31:16]) + CW'(cfg.tunnel_src_ip[15:0])
                       + CW'(cfg.tunnel_dst_ip[31:16]) + CW'(cfg.tunnel_dst_ip[15:0]);
        sum_reg  <= acc_reg + cfg_sum_reg;
        fold_reg <= 17'(sum_reg[15:0]) + 17'(sum_reg[CW-1:16]);
        cs_reg   <= ~(fold_reg[15:0] + 16'(fold_reg[16]));
    end

    a_decide_in_collect: assert property (@(posedge clk) disable iff (!rst_n)
        hdr.load |-> mode_reg == COLLECT && cnt_reg == HW'(gre_enc_pkg::HDR_BYTES - 1))
        else $error("header load outside of header collection");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        status.busy |-> !in_ready)
        else $error("item accepted during header burst");

    a_pass_after_qualify: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != PASS && mode_next == PASS |-> hdr.load && !in_last)
        else $error("pass mode entered without a tunneled header");

endmodule

// ===== rtl/gre_enc_emit.sv =====
// Header burst buffer and output register of the GRE encapsulator.
module gre_enc_emit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  gre_enc_pkg::hdr_load_t    hdr,
    input  gre_enc_pkg::pass_t        pass,
    input  logic                      out_ready,
    output gre_enc_pkg::emit_status_t status,
    output logic                      out_valid,
    output logic [7:0]                out_byte,
    output logic                      out_last
);

    localparam int EW = gre_enc_pkg::EMIT_CNT_W;

    gre_enc_pkg::frame_t buf_reg, buf_next;
    logic [EW-1:0]       cnt_reg, cnt_next;
    logic                last_reg, last_next;
    logic                ov_reg, ov_next;
    logic [7:0]          ob_reg, ob_next;
    logic                ol_reg, ol_next;
    logic                busy;
    logic                slot_free;

    assign busy      = cnt_reg != '0;
    assign slot_free = !ov_reg || out_ready;

    always_comb
    begin
        buf_next  = buf_reg;
        cnt_next  = cnt_reg;
        last_next = last_reg;
        ov_next   = ov_reg;
        ob_next   = ob_reg;
        ol_next   = ol_reg;
        if (slot_free)
        begin
            if (busy)
            begin
                ov_next  = 1'b1;
                ob_next  = buf_reg[0];
                ol_next  = last_reg && cnt_reg == EW'(1);
                buf_next = buf_reg >> 8;
                cnt_next = cnt_reg - 1'b1;
            end
            else if (pass.valid)
            begin
                ov_next = 1'b1;
                ob_next = pass.data;
                ol_next = pass.last;
            end
            else
            begin
                ov_next = 1'b0;
            end
        end
        if (hdr.load)
        begin
            buf_next  = hdr.frame;
            cnt_next  = EW'(gre_enc_pkg::OUT_HDR_BYTES);
            last_next = hdr.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg  <= buf_next;
        last_reg <= last_next;
        ob_reg   <= ob_next;
        ol_reg   <= ol_next;
    end

    assign status.busy      = busy;
    assign status.slot_free = slot_free;
    assign out_valid        = ov_reg;
    assign out_byte         = ob_reg;
    assign out_last         = ol_reg;

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        hdr.load |-> !busy)
        else $error("header load while burst in progress");

    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        hdr.load |=> cnt_reg == EW'(gre_enc_pkg::OUT_HDR_BYTES))
        else $error("burst count not loaded");

    a_pass_slot: assert property (@(posedge clk) disable iff (!rst_n)
        pass.valid |-> !busy && slot_free)
        else $error("pass item with no free output slot");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        busy && !slot_free |=> $stable(cnt_reg))
        else $error("burst advanced while output stalled");

endmodule
